>>> hw/rtl/pbp_pkg.sv
// Package for the perceptron branch predictor: sizes, row layout, queue item types.
// No dependencies; used by pbp_front, pbp_back and perceptron_branch_predictor.
`default_nettype none
package pbp_pkg;
   localparam int HIST_LEN   = 28;
   localparam int TABLE_ROWS = 512;
   localparam int ROW_W      = $clog2(TABLE_ROWS);
   localparam int ROW_LEN    = HIST_LEN + 1;
   localparam int WGT_W      = 8;
   localparam int ROW_BITS   = ROW_LEN * WGT_W;
   localparam int SUM_W      = 13;
   localparam int THR_W      = 12;
   localparam int NUM_GRP    = (ROW_LEN + 7) / 8;
   localparam logic [THR_W-1:0] THR_RESET = THR_W'(68);
   localparam logic signed [WGT_W-1:0] W_MIN = -8'sd128;
   localparam logic signed [WGT_W-1:0] W_MAX = 8'sd127;
   localparam logic OP_PREDICT = 1'b0;
   localparam logic OP_TRAIN   = 1'b1;

   typedef struct packed {
      logic             opcode;
      logic [ROW_W-1:0] row;
      logic             outcome;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } q_head_type;
endpackage
`default_nettype wire

>>> hw/rtl/pbp_front.sv
// Front end: accepts transactions and holds them in a two-entry queue.
// Depends on pbp_pkg.
`default_nettype none
module pbp_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  wire                  req_opcode,
   input  wire [31:0]           req_branch_address,
   input  wire                  req_branch_outcome,
   input  wire                  pop,
   output logic                 full,
   output pbp_pkg::q_head_type  head
);
   pbp_pkg::item_type q_ff [2];
   logic       wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_pop;

   assign full   = (cnt_ff == 2'd2);
   assign do_pop = pop && (cnt_ff != 2'd0);
   assign head.valid = (cnt_ff != 2'd0);
   assign head.item  = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = do_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // row is the address modulo the table size
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff].opcode  <= req_opcode;
         q_ff[wp_ff].row     <= req_branch_address[pbp_pkg::ROW_W-1:0];
         q_ff[wp_ff].outcome <= req_branch_outcome;
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/pbp_back.sv
// Back end: weight memory, clearing pass, sum tree, training and history.
// Depends on pbp_pkg.
`default_nettype none
module pbp_back (
   input  wire                                clock,
   input  wire                                reset,
   input  pbp_pkg::q_head_type                head,
   input  wire [pbp_pkg::THR_W-1:0]           threshold,
   output logic                               pop,
   output logic                               clearing,
   output logic                               rsp_valid,
   output logic                               rsp_predict_taken,
   output logic signed [pbp_pkg::SUM_W-1:0]   rsp_perceptron_sum
);
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_SUM   = 3'd3;
   localparam logic [2:0] S_FINAL = 3'd4;
   localparam logic [2:0] S_WRITE = 3'd5;

   logic [pbp_pkg::ROW_BITS-1:0] mem [pbp_pkg::TABLE_ROWS];
   logic [pbp_pkg::ROW_BITS-1:0] rd_ff, wb_ff, wb_in;
   logic [2:0]                   st_ff, st_in;
   logic [pbp_pkg::ROW_W-1:0]    clr_ff, clr_in;
   pbp_pkg::item_type            item_ff;
   logic [pbp_pkg::HIST_LEN-1:0] hist_ff, hist_in;
   logic signed [pbp_pkg::SUM_W-1:0] grp_ff [pbp_pkg::NUM_GRP];
   logic signed [pbp_pkg::SUM_W-1:0] grp_in [pbp_pkg::NUM_GRP];
   logic signed [pbp_pkg::SUM_W-1:0] total;
   logic [pbp_pkg::SUM_W-1:0]    mag;
   logic                         pred, upd_ff, upd_in;
   logic                         rv_ff, rp_ff;
   logic signed [pbp_pkg::SUM_W-1:0] rs_ff;
   logic                         mem_we;
   logic [pbp_pkg::ROW_W-1:0]    mem_waddr;
   logic [pbp_pkg::ROW_BITS-1:0] mem_wdata;

   assign clearing = (st_ff == S_CLEAR);
   assign pop      = (st_ff == S_IDLE) && head.valid;
   assign rsp_valid          = rv_ff;
   assign rsp_predict_taken  = rp_ff;
   assign rsp_perceptron_sum = rs_ff;

   // partial sums of up to eight signed terms each (the last group holds five)
   always_comb begin
      logic signed [pbp_pkg::SUM_W-1:0] w;
      int idx;
      for (int g = 0; g < pbp_pkg::NUM_GRP; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < 8; k++) begin
            idx = g * 8 + k;
            if (idx < pbp_pkg::ROW_LEN) begin
               w = pbp_pkg::SUM_W'($signed(rd_ff[idx*pbp_pkg::WGT_W +: pbp_pkg::WGT_W]));
               if (idx == 0 || hist_ff[(idx == 0) ? 0 : idx - 1])
                  grp_in[g] = grp_in[g] + w;
               else
                  grp_in[g] = grp_in[g] - w;
            end
         end
      end
   end

   always_comb begin
      total = '0;
      for (int g = 0; g < pbp_pkg::NUM_GRP; g++)
         total = total + grp_ff[g];
      pred = ~total[pbp_pkg::SUM_W-1];
      mag  = pred ? total : -total;
      upd_in = (item_ff.opcode == pbp_pkg::OP_TRAIN) &&
               ((mag <= {1'b0, threshold}) || (pred != item_ff.outcome));
   end

   // saturating step of every value by target times history sign
   always_comb begin
      logic signed [pbp_pkg::WGT_W-1:0] w;
      logic up;
      for (int j = 0; j < pbp_pkg::ROW_LEN; j++) begin
         w  = $signed(rd_ff[j*pbp_pkg::WGT_W +: pbp_pkg::WGT_W]);
         up = (j == 0) ? item_ff.outcome
                       : ~(item_ff.outcome ^ hist_ff[(j == 0) ? 0 : j - 1]);
         if (up)
            wb_in[j*pbp_pkg::WGT_W +: pbp_pkg::WGT_W] = (w == pbp_pkg::W_MAX) ? w : w + 8'sd1;
         else
            wb_in[j*pbp_pkg::WGT_W +: pbp_pkg::WGT_W] = (w == pbp_pkg::W_MIN) ? w : w - 8'sd1;
      end
   end

   always_comb begin
      st_in   = st_ff;
      clr_in  = clr_ff;
      hist_in = hist_ff;
      case (st_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == pbp_pkg::ROW_W'(pbp_pkg::TABLE_ROWS - 1)) st_in = S_IDLE;
         end
         S_IDLE:  if (head.valid) st_in = S_READ;
         S_READ:  st_in = S_SUM;
         S_SUM:   st_in = S_FINAL;
         S_FINAL: st_in = (item_ff.opcode == pbp_pkg::OP_TRAIN) ? S_WRITE : S_IDLE;
         S_WRITE: begin
            hist_in = {hist_ff[pbp_pkg::HIST_LEN-2:0], item_ff.outcome};
            st_in   = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
      mem_we    = clearing || ((st_ff == S_WRITE) && upd_ff);
      mem_waddr = clearing ? clr_ff : item_ff.row;
      mem_wdata = clearing ? '0 : wb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_CLEAR;
         clr_ff  <= '0;
         hist_ff <= '0;
         rv_ff   <= 1'b0;
      end else begin
         st_ff   <= st_in;
         clr_ff  <= clr_in;
         hist_ff <= hist_in;
         rv_ff   <= (st_ff == S_FINAL);
      end
   end

   always_ff @(posedge clock) begin
      if (pop) item_ff <= head.item;
      if (st_ff == S_SUM) grp_ff <= grp_in;
      if (st_ff == S_FINAL) begin
         rp_ff  <= pred;
         rs_ff  <= total;
         upd_ff <= upd_in;
         wb_ff  <= wb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_ff <= mem[item_ff.row];
   end
endmodule
`default_nettype wire

>>> hw/rtl/perceptron_branch_predictor.sv
// Top level of the perceptron branch predictor: threshold register, front and back.
// Depends on pbp_pkg, pbp_front and pbp_back.
// Flow: an accepted transaction is popped in idle and passes read, sum and final, which registers the result.
// Trains also pass write-back; the back end takes the next queued item only on return to idle.
// Reset: a clearing pass zeroes all 512 weight rows with busy held high;
// history clears and the threshold returns to 68 at once. Results cannot be stalled.
`default_nettype none
module perceptron_branch_predictor (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   output logic                              busy,
   input  wire                               req_opcode,
   input  wire [31:0]                        req_branch_address,
   input  wire                               req_branch_outcome,
   output logic                              rsp_valid,
   output logic                              rsp_predict_taken,
   output logic signed [pbp_pkg::SUM_W-1:0]  rsp_perceptron_sum,
   input  wire                               csr_write_enable,
   input  wire [pbp_pkg::THR_W-1:0]          csr_write_data
);
   logic [pbp_pkg::THR_W-1:0] thr_ff;
   logic                      full, clearing, pop;
   pbp_pkg::q_head_type       head;

   // hold off new transactions while the queue is full or memory is clearing
   assign busy = full || clearing;

   always_ff @(posedge clock) begin
      if (reset) thr_ff <= pbp_pkg::THR_RESET;
      else if (csr_write_enable) thr_ff <= csr_write_data;
   end

   pbp_front u_front (
      .clock              (clock),
      .reset              (reset),
      .push               (start && !busy),
      .req_opcode         (req_opcode),
      .req_branch_address (req_branch_address),
      .req_branch_outcome (req_branch_outcome),
      .pop                (pop),
      .full               (full),
      .head               (head)
   );

   pbp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .threshold          (thr_ff),
      .pop                (pop),
      .clearing           (clearing),
      .rsp_valid          (rsp_valid),
      .rsp_predict_taken  (rsp_predict_taken),
      .rsp_perceptron_sum (rsp_perceptron_sum)
   );
endmodule
`default_nettype wire
